// ===== sv/pmup_pkg.sv =====
// ============================================================================
// pmup_pkg: shared types and constants of the energy-meter link poller
// Function codes, result kinds, reply and request codes, and the job record
// that the front end hands to the back end.
// ============================================================================
package pmup_pkg;

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_POLL    = 2'd1,
        FUNC_INIT    = 2'd2,
        FUNC_TICK    = 2'd3
    } func_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TX_BYTE = 3'd0,
        KIND_VOLTAGE = 3'd1,
        KIND_CURRENT = 3'd2,
        KIND_POWER   = 3'd3,
        KIND_ENERGY  = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_MODULE_ADDRESS = 1'b0,
        CFG_IDLE_TIMEOUT   = 1'b1
    } cfg_index_t;

    localparam logic [31:0] MODULE_ADDRESS_RESET = 32'hC0A8_0101;
    localparam logic [15:0] IDLE_TIMEOUT_RESET   = 16'd500;

    // Reply type codes
    localparam logic [7:0] REPLY_VOLTAGE = 8'hA0;
    localparam logic [7:0] REPLY_CURRENT = 8'hA1;
    localparam logic [7:0] REPLY_POWER   = 8'hA2;
    localparam logic [7:0] REPLY_ENERGY  = 8'hA3;
    localparam logic [7:0] REPLY_ADDRESS = 8'hA4;

    // Request command codes
    localparam logic [7:0] REQ_VOLTAGE = 8'hB0;
    localparam logic [7:0] REQ_CURRENT = 8'hB1;
    localparam logic [7:0] REQ_POWER   = 8'hB2;
    localparam logic [7:0] REQ_ENERGY  = 8'hB3;
    localparam logic [7:0] REQ_ADDRESS = 8'hB4;

    // Frame layout: six data bytes and a check byte; bytes 0..3 are kept
    localparam int          FRAME_KEPT     = 4;
    localparam logic [2:0]  FRAME_DATA_LEN = 3'd6;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;
    localparam logic [23:0] SCALE_VOLTAGE  = 24'd10;
    localparam logic [23:0] SCALE_CURRENT  = 24'd100;

    // Request frame byte positions
    localparam logic [2:0] REQ_POS_CMD   = 3'd0;
    localparam logic [2:0] REQ_POS_ADDR3 = 3'd1;
    localparam logic [2:0] REQ_POS_ADDR2 = 3'd2;
    localparam logic [2:0] REQ_POS_ADDR1 = 3'd3;
    localparam logic [2:0] REQ_POS_ADDR0 = 3'd4;
    localparam logic [2:0] REQ_POS_ZERO  = 3'd5;
    localparam logic [2:0] REQ_POS_SUM   = 3'd6;

    // Job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One unit of work for the back end
    typedef struct packed {
        logic        has_reading;
        kind_t       kind;
        logic [23:0] reading;
        logic        has_req;
        logic [7:0]  cmd;
    } job_t;

endpackage

// ===== sv/power_meter_uart_poller.sv =====
// ============================================================================
// power_meter_uart_poller: energy-meter link poller
// Frames received bytes, checks replies and produces readings and the next
// request frame of the poll chain.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready, s_func, s_rx_byte) carries one event per
//   item: a received byte, a poll start, an init, or a millisecond tick.
//   Result channel (m_valid/m_ready, m_kind, m_tx_byte, m_reading, m_last)
//   carries readings and request bytes; m_last marks the final result that
//   one input item causes. Items that cause nothing produce no result.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 module address, 1 idle timeout) at the clock edge; write only while idle.
// Timing:
//   The front end takes one item per cycle while its four-entry job queue has
//   room. The first result of an item passes through the job queue and then
//   the output register. The back end emits one result per cycle while m_ready
//   is high; a poll or init gives seven results, a completed reply up to eight
//   (reading plus request); bytes and ticks ending no frame need no back end.
// Reset (aresetn low, synchronous): clear frame count, sum, idle timer, queue
//   and output valid; load register defaults (address 0xC0A80101, timeout 500).
// Stall: while m_ready is low the output register holds; jobs back up in the
//   queue, and s_ready drops once the queue is full.
// ============================================================================
module power_meter_uart_poller (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_rx_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_tx_byte,
    output logic [23:0] m_reading,
    output logic        m_last
);

    logic [31:0] address_reg;
    logic [15:0] timeout_reg;

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    pmup_pkg::job_t push_job;
    pmup_pkg::job_t head_job;

    // Configuration registers: write on enable, no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg <= pmup_pkg::MODULE_ADDRESS_RESET;
            timeout_reg <= pmup_pkg::IDLE_TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (pmup_pkg::cfg_index_t'(cfg_index))
                pmup_pkg::CFG_MODULE_ADDRESS: address_reg <= cfg_wdata;
                pmup_pkg::CFG_IDLE_TIMEOUT:   timeout_reg <= cfg_wdata[15:0];
            endcase
        end
    end

    // Front end: gather frames, run the idle timer, classify into jobs
    pmup_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_rx_byte (s_rx_byte),
        .timeout   (timeout_reg),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    // Decouple classification from result sequencing
    pmup_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back end: emit reading and request bytes, one per cycle unless stalled
    pmup_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head_job),
        .empty     (q_empty),
        .pop       (pop),
        .address   (address_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_tx_byte (m_tx_byte),
        .m_reading (m_reading),
        .m_last    (m_last)
    );

endmodule

// ===== sv/pmup_front.sv =====
// ============================================================================
// pmup_front: input handling and frame classification
// Gathers received bytes into frames, checks the sum, runs the idle timer and
// turns each item into at most one job for the back end.
// ============================================================================
module pmup_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_rx_byte,
    input  logic [15:0]       timeout,
    input  logic              q_full,
    output logic              push,
    output pmup_pkg::job_t    job
);

    logic [2:0]  cnt_reg,  cnt_next;
    logic [7:0]  sum_reg,  sum_next;
    logic [15:0] idle_reg, idle_next;
    logic [7:0]  frame_reg [pmup_pkg::FRAME_KEPT];

    logic        accept;
    logic [15:0] idle_inc;
    logic [15:0] hi16;
    logic [23:0] hi16_w;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign idle_inc = (idle_reg == pmup_pkg::IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign hi16     = {frame_reg[1], frame_reg[2]};
    assign hi16_w   = {8'd0, hi16};

    always_comb begin
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        idle_next = idle_reg;
        push      = 1'b0;
        job       = '0;
        job.kind  = pmup_pkg::KIND_TX_BYTE;
        if (accept) begin
            unique case (pmup_pkg::func_t'(s_func))
                pmup_pkg::FUNC_RX_BYTE: begin
                    if (cnt_reg < pmup_pkg::FRAME_DATA_LEN) begin
                        cnt_next = cnt_reg + 3'd1;
                        sum_next = sum_reg + s_rx_byte;
                    end else begin
                        cnt_next  = '0;
                        sum_next  = '0;
                        idle_next = '0;
                        if (s_rx_byte == sum_reg) begin
                            unique case (frame_reg[0])
                                pmup_pkg::REPLY_ADDRESS: begin
                                    push        = 1'b1;
                                    job.has_req = 1'b1;
                                    job.cmd     = pmup_pkg::REQ_VOLTAGE;
                                end
                                pmup_pkg::REPLY_VOLTAGE: begin
                                    push            = 1'b1;
                                    job.has_reading = 1'b1;
                                    job.kind        = pmup_pkg::KIND_VOLTAGE;
                                    job.reading     = hi16_w * pmup_pkg::SCALE_VOLTAGE
                                                      + {16'd0, frame_reg[3]};
                                    job.has_req     = 1'b1;
                                    job.cmd         = pmup_pkg::REQ_CURRENT;
                                end
                                pmup_pkg::REPLY_CURRENT: begin
                                    push            = 1'b1;
                                    job.has_reading = 1'b1;
                                    job.kind        = pmup_pkg::KIND_CURRENT;
                                    job.reading     = hi16_w * pmup_pkg::SCALE_CURRENT
                                                      + {16'd0, frame_reg[3]};
                                    job.has_req     = 1'b1;
                                    job.cmd         = pmup_pkg::REQ_POWER;
                                end
                                pmup_pkg::REPLY_POWER: begin
                                    push            = 1'b1;
                                    job.has_reading = 1'b1;
                                    job.kind        = pmup_pkg::KIND_POWER;
                                    job.reading     = hi16_w;
                                    job.has_req     = 1'b1;
                                    job.cmd         = pmup_pkg::REQ_ENERGY;
                                end
                                pmup_pkg::REPLY_ENERGY: begin
                                    push            = 1'b1;
                                    job.has_reading = 1'b1;
                                    job.kind        = pmup_pkg::KIND_ENERGY;
                                    job.reading     = {frame_reg[1], frame_reg[2], frame_reg[3]};
                                end
                                default: begin
                                    push = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                pmup_pkg::FUNC_POLL: begin
                    push        = 1'b1;
                    job.has_req = 1'b1;
                    job.cmd     = pmup_pkg::REQ_VOLTAGE;
                end
                pmup_pkg::FUNC_INIT: begin
                    push        = 1'b1;
                    job.has_req = 1'b1;
                    job.cmd     = pmup_pkg::REQ_ADDRESS;
                end
                pmup_pkg::FUNC_TICK: begin
                    idle_next = idle_inc;
                    if (idle_inc > timeout) begin
                        cnt_next  = '0;
                        sum_next  = '0;
                        idle_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            idle_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            idle_reg <= idle_next;
        end
    end

    // Frame bytes beyond the reading fields are never read: keep bytes 0..3
    always_ff @(posedge aclk) begin
        if (accept && pmup_pkg::func_t'(s_func) == pmup_pkg::FUNC_RX_BYTE
            && cnt_reg < 3'(pmup_pkg::FRAME_KEPT)) begin
            frame_reg[cnt_reg[1:0]] <= s_rx_byte;
        end
    end

endmodule

// ===== sv/pmup_queue.sv =====
// ============================================================================
// pmup_queue: job queue between front and back end
// Small synchronous FIFO of job records with full and empty flags.
// ============================================================================
module pmup_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pmup_pkg::job_t    push_job,
    input  logic              pop,
    output pmup_pkg::job_t    head,
    output logic              full,
    output logic              empty
);

    pmup_pkg::job_t                    mem [pmup_pkg::QUEUE_DEPTH];
    logic [pmup_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [pmup_pkg::QUEUE_CW-1:0]     count_reg;

    assign full  = count_reg == pmup_pkg::QUEUE_CW'(pmup_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    as_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("job pushed into full queue");
    as_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job popped from empty queue");
    as_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pmup_pkg::QUEUE_CW'(pmup_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== sv/pmup_back.sv =====
// ============================================================================
// pmup_back: result sequencer
// Walks the head job: optional reading, then the seven request bytes if any,
// one result per cycle into the output register while it is not stalled.
// ============================================================================
module pmup_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  pmup_pkg::job_t    head,
    input  logic              empty,
    output logic              pop,
    input  logic [31:0]       address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_tx_byte,
    output logic [23:0]       m_reading,
    output logic              m_last
);

    logic [2:0]  step_reg;
    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [7:0]  m_tx_byte_reg;
    logic [23:0] m_reading_reg;
    logic        m_last_reg;

    logic        advance;
    logic        load;
    logic        at_reading;
    logic        res_last;
    logic [2:0]  pos;
    logic [7:0]  req_byte;
    logic [7:0]  req_sum;

    assign advance    = !m_valid_reg || m_ready;
    assign load       = advance && !empty;
    assign at_reading = head.has_reading && step_reg == '0;
    assign pos        = step_reg - {2'b00, head.has_reading};
    assign res_last   = at_reading ? !head.has_req : (pos == pmup_pkg::REQ_POS_SUM);
    assign pop        = load && res_last;
    assign req_sum    = head.cmd + address[31:24] + address[23:16]
                        + address[15:8] + address[7:0];

    always_comb begin
        unique case (pos)
            pmup_pkg::REQ_POS_CMD:   req_byte = head.cmd;
            pmup_pkg::REQ_POS_ADDR3: req_byte = address[31:24];
            pmup_pkg::REQ_POS_ADDR2: req_byte = address[23:16];
            pmup_pkg::REQ_POS_ADDR1: req_byte = address[15:8];
            pmup_pkg::REQ_POS_ADDR0: req_byte = address[7:0];
            pmup_pkg::REQ_POS_ZERO:  req_byte = 8'd0;
            pmup_pkg::REQ_POS_SUM:   req_byte = req_sum;
            default:                 req_byte = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= !empty;
            if (load) begin
                step_reg <= res_last ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_last_reg <= res_last;
            if (at_reading) begin
                m_kind_reg    <= head.kind;
                m_tx_byte_reg <= 8'd0;
                m_reading_reg <= head.reading;
            end else begin
                m_kind_reg    <= pmup_pkg::KIND_TX_BYTE;
                m_tx_byte_reg <= req_byte;
                m_reading_reg <= 24'd0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_reading = m_reading_reg;
    assign m_last    = m_last_reg;

    as_step_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != '0 |-> !empty)
        else $error("sequencer mid-job with empty queue");
    as_pop_gives_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid && m_last)
        else $error("job retired without a last result");
    as_reading_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != pmup_pkg::KIND_TX_BYTE |-> m_tx_byte == 8'd0)
        else $error("reading result carries a transmit byte");

endmodule
